### rtl/slfb_pkg.sv
// Shared types, constants and codes for the status light fade/blink block.
package slfb_pkg;

    localparam int FULL_SCALE     = 1000;
    localparam int ORANGE_GREEN   = 500;
    localparam int FLIP_THRESHOLD = 98;
    localparam int INVERT_BASE    = 254;
    localparam int DUTY_MAX       = 255;

    // field widths
    localparam int STATUS_W = 2;
    localparam int DRAW_W   = 4;
    localparam int ROLL_W   = 7;
    localparam int LEVEL_W  = 12;
    localparam int STEP_W   = 5;
    localparam int COLOR_W  = 10;
    localparam int SCALE_W  = 10;
    localparam int BOUND_W  = 10;
    localparam int RAW_W    = 13;
    localparam int CFG_IDX_W = 3;

    localparam int IN_W  = STATUS_W + 2 * (DRAW_W + ROLL_W);
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 3 * COLOR_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // clamped level and divider widths
    localparam int CLAMP_W   = $clog2(FULL_SCALE + 1);
    localparam int DIV_STEPS = (CLAMP_W + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int DUTY_W    = CLAMP_W - 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int NUM_CH    = 3;
    localparam int CH_W      = 2;

    // reset values
    localparam int RED_CEIL_RST   = 800;
    localparam int BLUE_FLOOR_RST = 50;
    localparam int BLUE_CEIL_RST  = 900;
    localparam int LEVEL_RST      = 500;
    localparam int RED_STEP_RST   = 10;
    localparam int BLUE_STEP_RST  = -10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRIVER_MODE   = 3'd0,
        REG_INVERT_OUTPUT = 3'd1,
        REG_SCALE_DIVISOR = 3'd2,
        REG_RED_FLOOR     = 3'd3,
        REG_RED_CEILING   = 3'd4,
        REG_BLUE_FLOOR    = 3'd5,
        REG_BLUE_CEILING  = 3'd6
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_WARNING  = 2'd1,
        ST_CRITICAL = 2'd2,
        ST_UNKNOWN  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RUN,
        S_STORE,
        S_EMIT
    } ctrl_state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic            load;   // take input item, update fade/blink state
        logic            start;  // load divider with channel ch
        logic            step;   // one divider iteration (two quotient bits)
        logic            store;  // map quotient of channel ch into result slot
        logic            emit;   // move results into the output register
        logic [CH_W-1:0] ch;
    } dp_cmd_t;

endpackage

### rtl/status_light_fade_blink.sv
// Top level of the status light fade/blink block.
// Each input item is one status tick; each produces exactly one result item holding red,
// green and blue. Status 0 drifts the red and blue levels by their signed steps, renewing a
// step from the supplied draws when a level leaves its floor/ceiling window, or reversing it
// when the flip roll comes up 99 or more; any other status toggles a blink between a fixed
// color (yellow, red, orange) and black. Levels clamp to 0..1000 (PWM: 1..1000), divided by
// scale_divisor (0 = none), then passed through (driver_mode 1) or mapped to PWM duty x/4+1,
// optionally 254-duty. Sequence: from acceptance, an item gets a load step, then per color
// a divider load, five divider iterations (two quotient bits each, single shared divider)
// and a mapping step, then the handoff to the output register, held while it still waits.
// Items are handled one at a time; s_tready is high only while the sequencer is idle.
// The output register lets the next item be accepted while a result still waits on m_tready.
// Configuration writes are meant for idle periods only.
module status_light_fade_blink (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input item channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [1:0] status_code, [5:2] red_step_draw, [12:6] red_flip_roll,
    // [16:13] blue_step_draw, [23:17] blue_flip_roll
    input  logic [slfb_pkg::IN_TDATA_W-1:0]        s_tdata,
    // result item channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [9:0] red_out, [19:10] green_out, [29:20] blue_out, [31:30] zero
    output logic [slfb_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [slfb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [slfb_pkg::BOUND_W-1:0]           cfg_wdata
);

    slfb_pkg::dp_cmd_t              cmd;
    logic [slfb_pkg::OUT_W-1:0]     out_item;

    slfb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    slfb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_item   (s_tdata[slfb_pkg::IN_W-1:0]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_item  (out_item)
    );

    // pad to whole bytes
    assign m_tdata = slfb_pkg::OUT_TDATA_W'(out_item);

endmodule

### rtl/slfb_div.sv
// Shared restoring divider, two quotient bits per cycle while step is high.
module slfb_div (
    input  logic                            aclk,
    input  logic                            start,
    input  logic                            step,
    input  logic [slfb_pkg::CLAMP_W-1:0]    dividend,
    input  logic [slfb_pkg::SCALE_W-1:0]    divisor,
    output logic [slfb_pkg::CLAMP_W-1:0]    quotient
);

    logic [slfb_pkg::SCALE_W-1:0] rem_reg, rem_next;
    logic [slfb_pkg::DIV_W-1:0]   quo_reg, quo_next;

    always_comb begin
        logic [slfb_pkg::SCALE_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        if (start) begin
            rem_next = '0;
            quo_next = slfb_pkg::DIV_W'(dividend);
        end else if (step) begin
            for (int i = 0; i < 2; i++) begin
                trial    = {rem_next, quo_next[slfb_pkg::DIV_W-1]};
                quo_next = {quo_next[slfb_pkg::DIV_W-2:0], 1'b0};
                if (trial >= {1'b0, divisor}) begin
                    trial       = trial - {1'b0, divisor};
                    quo_next[0] = 1'b1;
                end
                rem_next = trial[slfb_pkg::SCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg[slfb_pkg::CLAMP_W-1:0];

endmodule

### rtl/slfb_dp.sv
// Datapath: config registers, fade/blink state, clamp, divide, PWM map, output register.
module slfb_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  slfb_pkg::dp_cmd_t                  cmd,
    input  logic [slfb_pkg::IN_W-1:0]          in_item,
    input  logic                               cfg_we,
    input  logic [slfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [slfb_pkg::BOUND_W-1:0]       cfg_wdata,
    output logic [slfb_pkg::OUT_W-1:0]         out_item
);

    typedef struct packed {
        logic signed [slfb_pkg::LEVEL_W-1:0] level;
        logic signed [slfb_pkg::STEP_W-1:0]  step;
    } fade_t;

    function automatic fade_t fade(
        input logic signed [slfb_pkg::LEVEL_W-1:0] level,
        input logic signed [slfb_pkg::STEP_W-1:0]  step,
        input logic [slfb_pkg::BOUND_W-1:0]        lo,
        input logic [slfb_pkg::BOUND_W-1:0]        hi,
        input logic [slfb_pkg::DRAW_W-1:0]         draw,
        input logic [slfb_pkg::ROLL_W-1:0]         roll
    );
        fade_t r;
        logic signed [slfb_pkg::STEP_W-1:0] d;
        r.level = level + slfb_pkg::LEVEL_W'(step);
        d       = $signed({1'b0, draw});
        if (r.level < $signed({2'b00, lo}))
            r.step = d;
        else if (r.level > $signed({2'b00, hi}))
            r.step = -d;
        else if (roll > slfb_pkg::ROLL_W'(slfb_pkg::FLIP_THRESHOLD))
            r.step = -step;
        else
            r.step = step;
        return r;
    endfunction

    function automatic logic [slfb_pkg::CLAMP_W-1:0] clamp(
        input logic signed [slfb_pkg::RAW_W-1:0] x,
        input logic                              mode
    );
        logic [slfb_pkg::CLAMP_W-1:0] c;
        if (x > $signed(slfb_pkg::RAW_W'(slfb_pkg::FULL_SCALE)))
            c = slfb_pkg::CLAMP_W'(slfb_pkg::FULL_SCALE);
        else if (x < $signed(slfb_pkg::RAW_W'(1)))
            c = mode ? '0 : slfb_pkg::CLAMP_W'(1);
        else
            c = x[slfb_pkg::CLAMP_W-1:0];
        return c;
    endfunction

    function automatic logic [slfb_pkg::COLOR_W-1:0] shape(
        input logic [slfb_pkg::CLAMP_W-1:0] q,
        input logic                         mode,
        input logic                         inv
    );
        logic [slfb_pkg::DUTY_W-1:0] duty;
        logic [7:0]                  d8;
        logic [slfb_pkg::COLOR_W-1:0] o;
        duty = slfb_pkg::DUTY_W'(q >> 2) + slfb_pkg::DUTY_W'(1);
        if (duty > slfb_pkg::DUTY_W'(slfb_pkg::DUTY_MAX))
            d8 = 8'(slfb_pkg::DUTY_MAX);
        else
            d8 = duty[7:0];
        if (inv)
            d8 = (d8 > 8'(slfb_pkg::INVERT_BASE)) ? 8'd0 : 8'(slfb_pkg::INVERT_BASE) - d8;
        if (mode)
            o = slfb_pkg::COLOR_W'(q);
        else
            o = slfb_pkg::COLOR_W'(d8);
        return o;
    endfunction

    // config registers
    logic                          drv_mode_reg, invert_reg;
    logic [slfb_pkg::SCALE_W-1:0]  scale_reg;
    logic [slfb_pkg::BOUND_W-1:0]  red_floor_reg, red_ceil_reg, blue_floor_reg, blue_ceil_reg;

    // fade/blink state
    logic signed [slfb_pkg::LEVEL_W-1:0] red_level_reg, blue_level_reg;
    logic signed [slfb_pkg::STEP_W-1:0]  red_step_reg, blue_step_reg;
    logic                                phase_reg, phase_next;

    logic [slfb_pkg::CLAMP_W-1:0] clamp_reg [slfb_pkg::NUM_CH];
    logic [slfb_pkg::COLOR_W-1:0] res_reg   [slfb_pkg::NUM_CH];
    logic [slfb_pkg::OUT_W-1:0]   out_reg;

    logic [slfb_pkg::STATUS_W-1:0] status;
    logic [slfb_pkg::DRAW_W-1:0]   red_draw, blue_draw;
    logic [slfb_pkg::ROLL_W-1:0]   red_roll, blue_roll;
    fade_t                         red_f, blue_f;
    logic signed [slfb_pkg::RAW_W-1:0] raw_r, raw_g, raw_b;
    logic [slfb_pkg::CLAMP_W-1:0]  quotient, qsel;

    assign status    = in_item[1:0];
    assign red_draw  = in_item[5:2];
    assign red_roll  = in_item[12:6];
    assign blue_draw = in_item[16:13];
    assign blue_roll = in_item[23:17];

    assign red_f  = fade(red_level_reg, red_step_reg, red_floor_reg, red_ceil_reg,
                         red_draw, red_roll);
    assign blue_f = fade(blue_level_reg, blue_step_reg, blue_floor_reg, blue_ceil_reg,
                         blue_draw, blue_roll);

    always_comb begin
        raw_r      = '0;
        raw_g      = '0;
        raw_b      = '0;
        phase_next = phase_reg;
        if (status == slfb_pkg::ST_OK) begin
            raw_r = slfb_pkg::RAW_W'(red_f.level);
            raw_b = slfb_pkg::RAW_W'(blue_f.level);
        end else if (phase_reg) begin
            raw_r      = slfb_pkg::RAW_W'(slfb_pkg::FULL_SCALE);
            phase_next = 1'b0;
            if (status == slfb_pkg::ST_WARNING)
                raw_g = slfb_pkg::RAW_W'(slfb_pkg::FULL_SCALE);
            else if (status == slfb_pkg::ST_UNKNOWN)
                raw_g = slfb_pkg::RAW_W'(slfb_pkg::ORANGE_GREEN);
        end else begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drv_mode_reg   <= 1'b0;
            invert_reg     <= 1'b0;
            scale_reg      <= '0;
            red_floor_reg  <= '0;
            red_ceil_reg   <= slfb_pkg::BOUND_W'(slfb_pkg::RED_CEIL_RST);
            blue_floor_reg <= slfb_pkg::BOUND_W'(slfb_pkg::BLUE_FLOOR_RST);
            blue_ceil_reg  <= slfb_pkg::BOUND_W'(slfb_pkg::BLUE_CEIL_RST);
        end else if (cfg_we) begin
            case (cfg_index)
                slfb_pkg::REG_DRIVER_MODE:   drv_mode_reg   <= cfg_wdata[0];
                slfb_pkg::REG_INVERT_OUTPUT: invert_reg     <= cfg_wdata[0];
                slfb_pkg::REG_SCALE_DIVISOR: scale_reg      <= cfg_wdata;
                slfb_pkg::REG_RED_FLOOR:     red_floor_reg  <= cfg_wdata;
                slfb_pkg::REG_RED_CEILING:   red_ceil_reg   <= cfg_wdata;
                slfb_pkg::REG_BLUE_FLOOR:    blue_floor_reg <= cfg_wdata;
                slfb_pkg::REG_BLUE_CEILING:  blue_ceil_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_level_reg  <= slfb_pkg::LEVEL_W'(slfb_pkg::LEVEL_RST);
            blue_level_reg <= slfb_pkg::LEVEL_W'(slfb_pkg::LEVEL_RST);
            red_step_reg   <= slfb_pkg::STEP_W'(slfb_pkg::RED_STEP_RST);
            blue_step_reg  <= slfb_pkg::STEP_W'(slfb_pkg::BLUE_STEP_RST);
            phase_reg      <= 1'b1;
        end else if (cmd.load) begin
            phase_reg <= phase_next;
            if (status == slfb_pkg::ST_OK) begin
                red_level_reg  <= red_f.level;
                red_step_reg   <= red_f.step;
                blue_level_reg <= blue_f.level;
                blue_step_reg  <= blue_f.step;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            clamp_reg[0] <= clamp(raw_r, drv_mode_reg);
            clamp_reg[1] <= clamp(raw_g, drv_mode_reg);
            clamp_reg[2] <= clamp(raw_b, drv_mode_reg);
        end
        if (cmd.store)
            res_reg[cmd.ch] <= shape(qsel, drv_mode_reg, invert_reg);
        if (cmd.emit)
            out_reg <= {res_reg[2], res_reg[1], res_reg[0]};
    end

    slfb_div u_div (
        .aclk     (aclk),
        .start    (cmd.start),
        .step     (cmd.step),
        .dividend (clamp_reg[cmd.ch]),
        .divisor  (scale_reg),
        .quotient (quotient)
    );

    // divisor zero means no scaling
    assign qsel = (scale_reg == '0) ? clamp_reg[cmd.ch] : quotient;

    assign out_item = out_reg;

endmodule

### rtl/slfb_ctrl.sv
// Controller: sequences load, three divisions, result mapping and output handoff.
module slfb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output slfb_pkg::dp_cmd_t cmd
);

    slfb_pkg::ctrl_state_t         state_reg, state_next;
    logic [slfb_pkg::CH_W-1:0]     ch_reg, ch_next;
    logic [slfb_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= slfb_pkg::S_IDLE;
            ch_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        s_tready   = 1'b0;
        case (state_reg)
            slfb_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    ch_next    = '0;
                    state_next = slfb_pkg::S_START;
                end
            end
            slfb_pkg::S_START: begin
                cmd.start  = 1'b1;
                cnt_next   = '0;
                state_next = slfb_pkg::S_RUN;
            end
            slfb_pkg::S_RUN: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == slfb_pkg::CNT_W'(slfb_pkg::DIV_STEPS - 1))
                    state_next = slfb_pkg::S_STORE;
            end
            slfb_pkg::S_STORE: begin
                cmd.store = 1'b1;
                if (ch_reg == slfb_pkg::CH_W'(slfb_pkg::NUM_CH - 1)) begin
                    state_next = slfb_pkg::S_EMIT;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = slfb_pkg::S_START;
                end
            end
            slfb_pkg::S_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = slfb_pkg::S_IDLE;
                end
            end
            default: state_next = slfb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

    a_emit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten while still waiting");

    a_load_then_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (cmd.start && ch_reg == '0))
        else $error("division did not start on first channel after load");

    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(cmd.emit))
        else $error("output valid without an emit");

    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start || cmd.store) |-> (ch_reg < slfb_pkg::CH_W'(slfb_pkg::NUM_CH)))
        else $error("channel index out of range");

endmodule

### dv/tb_status_light_fade_blink.sv
// Self-checking testbench for the status light fade/blink block.
`timescale 1ns / 100ps

// Test plan in short:
//  - one short directed list of ticks and register writes right after reset:
//    every blink color and its black phase, PWM and pass-through mapping,
//    inversion, the scale extremes, fade steps with flip rolls, a floor above
//    its ceiling, draws and rolls at the top of their fields
//  - then random phases; before each one the block is drained and every
//    register is rewritten, with windows that push the levels below zero and
//    past full scale, windows that are turned around, and scale 0 / 1 / full scale
//  - the sender and the receiver both pause at random per item, with calm
//    stretches that have no pauses at all
//  - a local color predictor keeps its own copy of the fade and blink state
//    and of the registers; every result is checked against the oldest
//    prediction
module tb_status_light_fade_blink;
    import slfb_pkg::*;

    localparam int SETTLE_CYCLES = 30;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 88;
    localparam int MAX_WAIT      = 12;

    // red in the low bits, as on m_tdata
    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } color_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        cfg_reg_t  reg_sel;
        int        value;
        status_t   status;
        int        rd, rr, bd, br;   // red draw/roll, blue draw/roll
        bit        typed;            // expected colors written in by hand
        color_t    want;
    } row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [BOUND_W-1:0]      cfg_wdata;

    // predictor copy of the registers
    logic               drv_mode;
    logic               inv_out;
    logic [SCALE_W-1:0] scale_div;
    logic [BOUND_W-1:0] red_lo, red_hi, blue_lo, blue_hi;

    // predictor copy of the fade and blink state
    logic signed [LEVEL_W-1:0] red_lvl, blue_lvl;
    logic signed [STEP_W-1:0]  red_stp, blue_stp;
    logic                      show_color;

    color_t expected_colors[$];
    int     mismatch_count;
    int     result_count;
    int     src_calm;       // items left in a no-pause stretch, sender
    int     snk_calm;       // same, receiver

    status_light_fade_blink u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t result %0d: %s", $realtime, result_count, msg);
        mismatch_count++;
    endtask

    // Move one level by its old step, then renew the step: below the floor
    // takes +draw, above the ceiling -draw (floor test first), else a roll
    // above the threshold turns the step around. Both wrap at their widths.
    function automatic void fade_level(inout logic signed [LEVEL_W-1:0] lvl,
                                       inout logic signed [STEP_W-1:0] stp,
                                       input int lo, input int hi,
                                       input int draw, input int roll);
        int sum, nxt;
        sum = int'(lvl) + int'(stp);
        lvl = sum[LEVEL_W-1:0];
        if (int'(lvl) < lo)
            nxt = draw;
        else if (int'(lvl) > hi)
            nxt = -draw;
        else if (roll > FLIP_THRESHOLD)
            nxt = -int'(stp);
        else
            nxt = int'(stp);
        stp = nxt[STEP_W-1:0];
    endfunction

    // clamp, scale, then pass through or map to a PWM duty
    function automatic logic [COLOR_W-1:0] to_output(input int x);
        int v, duty;
        v = x;
        if (v > FULL_SCALE)
            v = FULL_SCALE;
        if (v < 1)
            v = drv_mode ? 0 : 1;       // PWM never goes fully dark
        if (scale_div != 0)
            v = v / int'(scale_div);
        if (drv_mode)
            return v[COLOR_W-1:0];
        duty = v / 4 + 1;
        if (duty > DUTY_MAX)
            duty = DUTY_MAX;
        if (inv_out) begin
            duty = INVERT_BASE - duty;
            if (duty < 0)
                duty = 0;
        end
        return duty[COLOR_W-1:0];
    endfunction

    // one accepted tick: update state, return the colors it shows
    function automatic color_t predict_tick(input status_t st, input int rd, input int rr,
                                            input int bd, input int br);
        int r, g, b;
        color_t c;
        r = 0;
        g = 0;
        b = 0;
        if (st == ST_OK) begin
            // fade tick leaves the blink phase alone, green gets level 0
            fade_level(red_lvl, red_stp, int'(red_lo), int'(red_hi), rd, rr);
            fade_level(blue_lvl, blue_stp, int'(blue_lo), int'(blue_hi), bd, br);
            r = int'(red_lvl);
            b = int'(blue_lvl);
        end else if (show_color) begin
            r = FULL_SCALE;
            if (st == ST_WARNING)
                g = FULL_SCALE;
            else if (st == ST_UNKNOWN)
                g = ORANGE_GREEN;
            show_color = 1'b0;
        end else begin
            show_color = 1'b1;
        end
        c.red   = to_output(r);
        c.green = to_output(g);
        c.blue  = to_output(b);
        return c;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_tick(input status_t st, input int rd,
                                                        input int rr, input int bd,
                                                        input int br);
        logic [IN_TDATA_W-1:0] w;
        w = '0;
        w[IN_W-1:0] = {br[ROLL_W-1:0], bd[DRAW_W-1:0], rr[ROLL_W-1:0], rd[DRAW_W-1:0], st};
        return w;
    endfunction

    function automatic row_t tick_row(input status_t st, input int rd, input int rr,
                                      input int bd, input int br, input bit typed = 1'b0,
                                      input int r = 0, input int g = 0, input int b = 0);
        row_t row;
        row.kind       = ROW_ITEM;
        row.reg_sel    = REG_DRIVER_MODE;
        row.value      = 0;
        row.status     = st;
        row.rd         = rd;
        row.rr         = rr;
        row.bd         = bd;
        row.br         = br;
        row.typed      = typed;
        row.want.red   = r[COLOR_W-1:0];
        row.want.green = g[COLOR_W-1:0];
        row.want.blue  = b[COLOR_W-1:0];
        return row;
    endfunction

    function automatic row_t cfg_row(input cfg_reg_t sel, input int val);
        row_t row;
        row = tick_row(ST_OK, 0, 0, 0, 0);
        row.kind    = ROW_CFG;
        row.reg_sel = sel;
        row.value   = val;
        return row;
    endfunction

    function automatic int pick_draw();
        // mostly nonzero so fades keep moving; now and then the full 4 bits
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 15);
        return $urandom_range(1, 9);
    endfunction

    function automatic int pick_roll();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(FLIP_THRESHOLD + 1, 127);
            1:       return $urandom_range(0, 127);
            default: return $urandom_range(0, FLIP_THRESHOLD);
        endcase
    endfunction

    // Drive one tick after a random pause; valid stays high across
    // back-to-back items. The prediction is queued at acceptance.
    task automatic send_tick(input status_t st, input int rd, input int rr, input int bd,
                             input int br, input bit typed, input color_t want);
        int gap;
        color_t c;
        if (src_calm > 0) begin
            src_calm--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 15) == 0)
                src_calm = $urandom_range(8, 40);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_tick(st, rd, rr, bd, br);
        do @(posedge aclk); while (!s_tready);
        c = predict_tick(st, rd, rr, bd, br);
        expected_colors.push_back(typed ? want : c);
    endtask

    // registers only change with the block idle
    task automatic write_reg(input cfg_reg_t sel, input int val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val[BOUND_W-1:0];
        case (sel)
            REG_DRIVER_MODE:   drv_mode  = val[0];
            REG_INVERT_OUTPUT: inv_out   = val[0];
            REG_SCALE_DIVISOR: scale_div = val[SCALE_W-1:0];
            REG_RED_FLOOR:     red_lo    = val[BOUND_W-1:0];
            REG_RED_CEILING:   red_hi    = val[BOUND_W-1:0];
            REG_BLUE_FLOOR:    blue_lo   = val[BOUND_W-1:0];
            REG_BLUE_CEILING:  blue_hi   = val[BOUND_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // stop sending, wait for every result, then let the sequencer settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Rewrite all registers for one random phase. Window kinds last two
    // phases so the levels have time to travel into them.
    task automatic set_phase(input int p);
        int lo_r, hi_r, lo_b, hi_b, scale;
        case ((p / 3) % 4)
            0:       scale = 0;
            1:       scale = 1;
            2:       scale = FULL_SCALE;
            default: scale = $urandom_range(2, FULL_SCALE - 1);
        endcase
        case ((p / 2) % 5)
            0: begin            // full range
                lo_r = 0;
                hi_r = FULL_SCALE;
                lo_b = 0;
                hi_b = FULL_SCALE;
            end
            1: begin            // hugging zero: levels dip negative
                lo_r = 0;
                hi_r = $urandom_range(0, 150);
                lo_b = $urandom_range(0, 20);
                hi_b = $urandom_range(20, 200);
            end
            2: begin            // hugging full scale: levels overshoot
                lo_r = $urandom_range(850, FULL_SCALE);
                hi_r = FULL_SCALE;
                lo_b = $urandom_range(800, 990);
                hi_b = $urandom_range(lo_b, FULL_SCALE);
            end
            3: begin            // floor above ceiling
                lo_r = $urandom_range(500, FULL_SCALE);
                hi_r = $urandom_range(0, 499);
                lo_b = $urandom_range(300, FULL_SCALE);
                hi_b = $urandom_range(0, lo_b - 1);
            end
            default: begin
                lo_r = $urandom_range(0, 900);
                hi_r = $urandom_range(lo_r, FULL_SCALE);
                lo_b = $urandom_range(0, 900);
                hi_b = $urandom_range(lo_b, FULL_SCALE);
            end
        endcase
        write_reg(REG_DRIVER_MODE, p % 2);
        write_reg(REG_INVERT_OUTPUT, $urandom_range(0, 1));
        write_reg(REG_SCALE_DIVISOR, scale);
        write_reg(REG_RED_FLOOR, lo_r);
        write_reg(REG_RED_CEILING, hi_r);
        write_reg(REG_BLUE_FLOOR, lo_b);
        write_reg(REG_BLUE_CEILING, hi_b);
    endtask

    // result side: random stalls, check each item against the oldest prediction
    initial begin
        int stall;
        color_t got, want;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (snk_calm > 0) begin
                snk_calm--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 15) == 0)
                    snk_calm = $urandom_range(8, 40);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = m_tdata[OUT_W-1:0];
            if (expected_colors.size() == 0) begin
                report_mismatch($sformatf("unexpected item %h", got));
            end else begin
                want = expected_colors.pop_front();
                if (got.red !== want.red)
                    report_mismatch($sformatf("red_out %0d, want %0d", got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green_out %0d, want %0d",
                                              got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("blue_out %0d, want %0d", got.blue, want.blue));
            end
            result_count++;
            @(negedge aclk);
        end
    end

    // stimulus
    initial begin
        row_t plan[$];
        bit prev_item;
        status_t st;
        int rd, rr, bd, br;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        mismatch_count = 0;
        result_count   = 0;
        src_calm = 0;
        snk_calm = 0;

        // predictor starts from the reset values
        drv_mode   = 1'b0;
        inv_out    = 1'b0;
        scale_div  = '0;
        red_lo     = '0;
        red_hi     = BOUND_W'(RED_CEIL_RST);
        blue_lo    = BOUND_W'(BLUE_FLOOR_RST);
        blue_hi    = BOUND_W'(BLUE_CEIL_RST);
        red_lvl    = LEVEL_W'(LEVEL_RST);
        blue_lvl   = LEVEL_W'(LEVEL_RST);
        red_stp    = STEP_W'(RED_STEP_RST);
        blue_stp   = STEP_W'(BLUE_STEP_RST);
        show_color = 1'b1;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed list, reset registers first: PWM, no invert, no scale
        plan.push_back(tick_row(ST_WARNING,  0, 0, 0, 0, 1, 251, 251, 1));  // yellow
        plan.push_back(tick_row(ST_CRITICAL, 0, 0, 0, 0, 1, 1, 1, 1));      // black
        plan.push_back(tick_row(ST_CRITICAL, 0, 0, 0, 0, 1, 251, 1, 1));    // red
        plan.push_back(tick_row(ST_UNKNOWN,  0, 0, 0, 0, 1, 1, 1, 1));
        plan.push_back(tick_row(ST_UNKNOWN, 15, 127, 15, 127, 1, 251, 126, 1));  // orange
        plan.push_back(tick_row(ST_OK, 0, 0, 0, 0, 1, 128, 1, 123));        // plain fade
        plan.push_back(tick_row(ST_OK, 9, 99, 9, 99));                     // both steps flip
        plan.push_back(tick_row(ST_OK, 15, 127, 15, 127));                 // flip back
        plan.push_back(tick_row(ST_WARNING, 15, 127, 15, 127));            // black phase
        plan.push_back(cfg_row(REG_INVERT_OUTPUT, 1));
        plan.push_back(tick_row(ST_WARNING, 0, 0, 0, 0, 1, 3, 3, 253));
        plan.push_back(cfg_row(REG_SCALE_DIVISOR, FULL_SCALE));
        plan.push_back(tick_row(ST_UNKNOWN, 0, 0, 0, 0));
        plan.push_back(tick_row(ST_UNKNOWN, 0, 0, 0, 0, 1, 253, 253, 253));
        plan.push_back(cfg_row(REG_DRIVER_MODE, 1));
        plan.push_back(tick_row(ST_CRITICAL, 0, 0, 0, 0, 1, 0, 0, 0));
        plan.push_back(cfg_row(REG_SCALE_DIVISOR, 0));
        plan.push_back(tick_row(ST_CRITICAL, 0, 0, 0, 0, 1, FULL_SCALE, 0, 0));
        // red floor above its ceiling: the floor test wins
        plan.push_back(cfg_row(REG_RED_FLOOR, FULL_SCALE));
        plan.push_back(cfg_row(REG_RED_CEILING, 0));
        plan.push_back(cfg_row(REG_BLUE_FLOOR, 0));
        plan.push_back(cfg_row(REG_BLUE_CEILING, 0));
        plan.push_back(tick_row(ST_OK, 15, 99, 15, 99));
        plan.push_back(tick_row(ST_OK, 0, 0, 0, 0));
        plan.push_back(tick_row(ST_OK, 7, 50, 3, 127));

        prev_item = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                if (prev_item)
                    drain();
                write_reg(plan[i].reg_sel, plan[i].value);
                prev_item = 1'b0;
            end else begin
                send_tick(plan[i].status, plan[i].rd, plan[i].rr, plan[i].bd, plan[i].br,
                          plan[i].typed, plan[i].want);
                prev_item = 1'b1;
            end
        end

        // random phases: mostly fade ticks so the levels reach their bounds
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            set_phase(p);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 80)
                    st = ST_OK;
                else
                    st = status_t'($urandom_range(1, 3));
                rd = pick_draw();
                rr = pick_roll();
                bd = pick_draw();
                br = pick_roll();
                send_tick(st, rd, rr, bd, br, 1'b0, '0);
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
rtl/slfb_pkg.sv
rtl/slfb_div.sv
rtl/slfb_dp.sv
rtl/slfb_ctrl.sv
rtl/status_light_fade_blink.sv
dv/tb_status_light_fade_blink.sv
